// ===== hw/rtl/rit_pkg.sv =====
// ---------------------------------------------------------------------------
// rit_pkg
// Shared types, constants and the digit symbol map for radix_integer_to_text.
// ---------------------------------------------------------------------------
`default_nettype none

package rit_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned DIGIT_CAP  = 32;
  localparam int unsigned DIG_IDX_W  = $clog2(DIGIT_CAP);
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned STEPS_PER_DIGIT = VALUE_BITS / BITS_PER_STEP;

  localparam logic [7:0] BASE_MIN  = 8'd2;
  localparam logic [7:0] BASE_MAX  = 8'd62;
  localparam logic [5:0] CAP6      = 6'd32;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOWER  = 8'h61;
  localparam logic [7:0] CH_UPPER  = 8'h41;
  localparam logic [7:0] CH_MINUS  = 8'h2d;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  base;
    logic [5:0]  min_width;
    logic [5:0]  max_digits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } out_word_t;

  // classified conversion job handed from front to back
  typedef struct packed {
    logic        empty;
    logic        neg;
    logic [31:0] mag;
    logic [5:0]  base;
    logic [5:0]  minw;
    logic [5:0]  maxd;
  } cmd_t;

  function automatic logic [7:0] digit_sym(input logic [5:0] d);
    logic [7:0] w;
    w = {2'b00, d};
    if (d < 6'd10) begin
      return CH_ZERO + w;
    end else if (d < 6'd36) begin
      return CH_LOWER + w - 8'd10;
    end else begin
      return CH_UPPER + w - 8'd36;
    end
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rit_front.sv =====
// ---------------------------------------------------------------------------
// rit_front
// Accepts input words, classifies them into jobs and queues up to two of them.
// ---------------------------------------------------------------------------
`default_nettype none

module rit_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rit_pkg::in_word_t in_data,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output rit_pkg::cmd_t          cmd
);

  rit_pkg::cmd_t cls;
  rit_pkg::cmd_t q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  logic       bad_base;

  always_comb begin
    bad_base  = (in_data.base < rit_pkg::BASE_MIN) || (in_data.base > rit_pkg::BASE_MAX);
    cls.neg   = in_data.value[31];
    cls.mag   = in_data.value[31] ? (~in_data.value + 32'd1) : in_data.value;
    cls.base  = in_data.base[5:0];
    cls.minw  = (in_data.min_width > rit_pkg::CAP6) ? rit_pkg::CAP6 : in_data.min_width;
    cls.maxd  = (in_data.max_digits > rit_pkg::CAP6) ? rit_pkg::CAP6 : in_data.max_digits;
    cls.empty = bad_base ||
                (!cls.neg && (cls.minw == 6'd0) && ((cls.mag == 32'd0) || (cls.maxd == 6'd0)));
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r)) else $error("queue pointers out of step");

  a_ptr_even: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd1) |-> (wr_ptr_r == rd_ptr_r)) else $error("queue pointers diverged");

endmodule

`default_nettype wire

// ===== hw/rtl/rit_back.sv =====
// ---------------------------------------------------------------------------
// rit_back
// Divides the magnitude down digit by digit, then emits sign, pads and digits, or one empty word.
// ---------------------------------------------------------------------------
`default_nettype none

module rit_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire rit_pkg::cmd_t  cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rit_pkg::out_word_t  out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;
  localparam logic [2:0] STEP_LAST = 3'(rit_pkg::STEPS_PER_DIGIT - 1);

  logic [1:0]  state_r, state_nxt;
  logic        empty_r, empty_nxt;
  logic        sign_r, sign_nxt;
  logic [5:0]  base_r, base_nxt;
  logic [5:0]  minw_r, minw_nxt;
  logic [5:0]  maxd_r, maxd_nxt;
  logic [5:0]  count_r, count_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [2:0]  step_r, step_nxt;
  logic        out_valid_r, out_valid_nxt;
  rit_pkg::out_word_t out_data_r, out_data_nxt;
  logic [5:0]  digs_r [rit_pkg::DIGIT_CAP];

  logic [31:0] div_quo;
  logic [5:0]  div_rem;
  logic [5:0]  cnt_inc;
  logic [5:0]  idx;
  logic        can_load;
  logic        dig_wr;
  logic [7:0]  dig_ch;

  // four restoring division steps per cycle
  always_comb begin
    logic [6:0]  r;
    logic [31:0] d;
    r = {1'b0, rem_r};
    d = quo_r;
    for (int i = 0; i < rit_pkg::BITS_PER_STEP; i++) begin
      r = {r[5:0], d[31]};
      d = {d[30:0], 1'b0};
      if (r >= {1'b0, base_r}) begin
        r    = r - {1'b0, base_r};
        d[0] = 1'b1;
      end
    end
    div_quo = d;
    div_rem = r[5:0];
  end

  assign cnt_inc   = count_r + 6'd1;
  assign idx       = pos_r - 6'd1;
  assign can_load  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == ST_IDLE);
  assign dig_ch    = (idx < count_r) ? rit_pkg::digit_sym(digs_r[idx[rit_pkg::DIG_IDX_W-1:0]])
                                     : rit_pkg::CH_ZERO;
  assign dig_wr    = (state_r == ST_DIV) && (step_r == STEP_LAST);

  always_comb begin
    state_nxt     = state_r;
    empty_nxt     = empty_r;
    sign_nxt      = sign_r;
    base_nxt      = base_r;
    minw_nxt      = minw_r;
    maxd_nxt      = maxd_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          empty_nxt = cmd.empty;
          sign_nxt  = cmd.neg;
          base_nxt  = cmd.base;
          minw_nxt  = cmd.minw;
          maxd_nxt  = cmd.maxd;
          quo_nxt   = cmd.mag;
          rem_nxt   = 6'd0;
          step_nxt  = 3'd0;
          count_nxt = 6'd0;
          pos_nxt   = cmd.minw;
          if (!cmd.empty && (cmd.mag != 32'd0) && (cmd.maxd != 6'd0)) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        step_nxt = step_r + 3'd1;
        quo_nxt  = div_quo;
        rem_nxt  = div_rem;
        if (step_r == STEP_LAST) begin
          count_nxt = cnt_inc;
          rem_nxt   = 6'd0;
          if ((cnt_inc == maxd_r) || (div_quo == 32'd0)) begin
            pos_nxt   = (cnt_inc > minw_r) ? cnt_inc : minw_r;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          if (empty_r) begin
            out_data_nxt = '{ch: 8'd0, has_char: 1'b0, last: 1'b1};
            state_nxt    = ST_IDLE;
          end else if (sign_r) begin
            out_data_nxt = '{ch: rit_pkg::CH_MINUS, has_char: 1'b1, last: (pos_r == 6'd0)};
            sign_nxt     = 1'b0;
            if (pos_r == 6'd0) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_data_nxt = '{ch: dig_ch, has_char: 1'b1, last: (idx == 6'd0)};
            pos_nxt      = idx;
            if (idx == 6'd0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    empty_r    <= empty_nxt;
    sign_r     <= sign_nxt;
    base_r     <= base_nxt;
    minw_r     <= minw_nxt;
    maxd_r     <= maxd_nxt;
    count_r    <= count_nxt;
    pos_r      <= pos_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
    if (dig_wr) begin
      digs_r[count_r[rit_pkg::DIG_IDX_W-1:0]] <= div_rem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < base_r)) else $error("remainder not below base");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (count_r <= maxd_r)) else $error("digit count past limit");

  a_digit_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !empty_r && !sign_r) |-> (pos_r != 6'd0))
    else $error("digit emit with nothing left");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |=> (state_r != ST_IDLE)) else $error("job dropped");

endmodule

`default_nettype wire

// ===== hw/rtl/radix_integer_to_text.sv =====
// ---------------------------------------------------------------------------
// radix_integer_to_text
// Signed 32-bit integer to ASCII text in radix 2..62, one character a word.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): value, base, min_width and
// max_digits. Output channel (out_valid/out_ready/out_data): one character
// per word, most significant first; '-' leads a negative value, '0' pads
// to min_width, last marks the final word. A bad base, or text that would
// be empty, gives one word with has_char low and last high.
// The digit divider retires 4 quotient bits a cycle. The back end works
// on one conversion at a time, divider and emission alike; a two-entry
// job queue in front keeps accepting input meanwhile.
// Reset clears the queue, the sequencer and the output valid flag.
// A stalled receiver holds the current word and freezes character emission;
// the queue fills and in_ready drops once two jobs wait.
// ---------------------------------------------------------------------------
`default_nettype none

module radix_integer_to_text (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rit_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rit_pkg::out_word_t      out_data
);

  logic          cmd_valid;
  logic          cmd_ready;
  rit_pkg::cmd_t cmd;

  rit_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  rit_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
